// ===== design/dcsc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcsc_pkg
// Types, register codes and constants of the DC blocker / soft clip block,
// plus the elaboration-time generator for the tanh lookup points.
// ---------------------------------------------------------------------------
package dcsc_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int FRAC_BITS      = 20;
   localparam int SCALE_SHIFT    = SAMPLE_BITS - 1;   // log2 of full scale
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int POLE_BITS      = 16;
   localparam int MAC_W          = SAMPLE_BITS + 1;
   localparam int ADD_W          = SAMPLE_BITS;
   localparam int PROD_W         = 2 * MAC_W;

   localparam logic [POLE_BITS-1:0] POLE_MIN   = 16'd64880;
   localparam logic [POLE_BITS-1:0] POLE_RESET = 16'd65492;

   localparam longint ONE_Q30      = 64'sd1 <<< 30;
   localparam longint EXP_NEG1_Q30 = 64'sd395007542;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DC_ENABLE   = 2'd0,
      CSR_CLIP_ENABLE = 2'd1,
      CSR_POLE_COEFF  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          chan;
      logic                          bad_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          out_chan;
   } rsp_type;

   // operands of the shared multiply-add: p = a * b + c
   typedef struct packed {
      logic signed [MAC_W-1:0] a;
      logic signed [MAC_W-1:0] b;
      logic signed [ADD_W-1:0] c;
   } mac_op_type;

   // shift-subtract division, evaluated only while building constants
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-t) in Q2.30, t >= 0 in Q.20
   function automatic longint exp_neg_q30(input longint t);
      longint whole;
      longint f;
      longint r;
      longint term;
      longint sum;
      whole = t >>> FRAC_BITS;
      f     = (t & ((64'sd1 <<< FRAC_BITS) - 64'sd1)) <<< (30 - FRAC_BITS);
      r     = ONE_Q30;
      term  = ONE_Q30;
      sum   = ONE_Q30;
      for (longint n = 0; n < whole && r != 0; n++) begin
         r = (r * EXP_NEG1_Q30 + (64'sd1 <<< 29)) >>> 30;
      end
      for (int k = 1; k <= 14; k++) begin
         term = longint'(udiv64(64'((term * f) >>> 30), 64'(k)));
         if ((k & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return (r * sum) >>> 30;
   endfunction

   // tanh at point i of a table with depth intervals over [0, full scale]
   function automatic logic [SAMPLE_BITS-1:0] tanh_point(input int i, input int depth);
      logic [63:0] a;
      logic [63:0] num;
      logic [63:0] den;
      longint      u;
      a   = udiv64(64'(i) << SCALE_SHIFT, 64'(depth));
      u   = exp_neg_q30(longint'(a << 1));
      num = 64'(ONE_Q30 - u) << FRAC_BITS;
      den = 64'(ONE_Q30 + u);
      return SAMPLE_BITS'(udiv64(num + (den >> 1), den));
   endfunction

endpackage
`default_nettype wire

// ===== design/dc_block_soft_clip.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dc_block_soft_clip
// Per-channel DC blocker followed by a table-based tanh soft clip.
//
// req_* carries one Q3.20 sample, its channel and an invalid flag; an invalid
// sample is taken as zero. rsp_* returns the conditioned sample and channel.
// csr_* is a plain write port: index 0 dc_enable, 1 clip_enable, 2 pole_coeff
// (Q0.16, clamped to 64880 at use); other indexes are ignored.
// One transaction is worked at a time; req_ready is high only while idle.
// Steps from acceptance to rsp_valid: DC blocker DC_MUL, DC_SUM; soft clip
//   CLIP_POS, CLIP_IDX, CLIP_LO, CLIP_HI, CLIP_INT; then FINISH. A disabled
//   stage is skipped, and CLIP_HI and CLIP_INT when |x| hits the last point.
// req_ready returns in the same cycle that rsp_valid rises.
// The step sequence follows from the single shared multiply-add and the
// single-port tanh table, read once per point.
// A finished result sits in the output register; a new transaction is taken
// while it waits, but the next result holds until the receiver takes it.
// Reset (synchronous) zeroes the filter state, restores the register reset
// values and drops rsp_valid. No clearing pass is needed.
// ---------------------------------------------------------------------------
module dc_block_soft_clip #(
   parameter int CHANNELS         = 2,
   parameter int CLIP_TABLE_DEPTH = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire dcsc_pkg::req_type                     req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output dcsc_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_write_en,
   input  wire logic [dcsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [dcsc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int SB        = dcsc_pkg::SAMPLE_BITS;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ROM_DEPTH = CLIP_TABLE_DEPTH + 1;
   localparam int AW        = $clog2(ROM_DEPTH);
   localparam int SHIFT     = dcsc_pkg::SCALE_SHIFT;
   localparam int PW        = dcsc_pkg::PROD_W;
   localparam int MW        = dcsc_pkg::MAC_W;
   localparam int SUM_W     = SB + 3;

   localparam logic [AW-1:0] IDX_LAST = AW'(CLIP_TABLE_DEPTH);
   localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

   typedef logic [SB-1:0] rom_type [ROM_DEPTH];

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         t[i] = dcsc_pkg::tanh_point(i, CLIP_TABLE_DEPTH);
      end
      return t;
   endfunction

   localparam rom_type TANH_ROM = build_rom();

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DC_MUL,
      ST_DC_SUM,
      ST_CLIP_POS,
      ST_CLIP_IDX,
      ST_CLIP_LO,
      ST_CLIP_HI,
      ST_CLIP_INT,
      ST_FINISH
   } state_type;

   // configuration
   logic                               dc_en_ff;
   logic                               clip_en_ff;
   logic [dcsc_pkg::POLE_BITS-1:0]     pole_ff;
   logic [dcsc_pkg::POLE_BITS-1:0]     pole_use;

   // channel state
   logic signed [SB-1:0]               prev_in_ff  [CHANNELS];
   logic signed [SB-1:0]               prev_out_ff [CHANNELS];

   // sequencer
   state_type                          state_ff, state_in;
   logic signed [SB-1:0]               x_ff, x_in;
   logic [CH_W-1:0]                    cidx_ff, cidx_in;
   logic                               chan_ff, chan_in;
   logic                               sign_ff, sign_in;
   logic [AW-1:0]                      idx_ff, idx_in;
   logic [SHIFT-1:0]                   frac_ff, frac_in;
   logic [SB-1:0]                      lo_ff, lo_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   dcsc_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic                               state_we;
   logic signed [SB-1:0]               y_sat;

   // table
   logic [AW-1:0]                      rom_addr;
   logic [SB-1:0]                      rom_q_ff;

   // shared unit
   dcsc_pkg::mac_op_type               mac_op;
   logic signed [PW-1:0]               mac_p;

   // datapath helpers
   logic signed [MW-1:0]               rnd;
   logic signed [SUM_W-1:0]            y_wide;
   logic signed [MW-1:0]               mag;
   logic [SB-1:0]                      diff;
   logic [SB-1:0]                      interp;

   dcsc_mac u_mac (
      .clock   (clock),
      .op      (mac_op),
      .prod_ff (mac_p)
   );

   assign pole_use = (pole_ff < dcsc_pkg::POLE_MIN) ? dcsc_pkg::POLE_MIN : pole_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_en_ff   <= 1'b1;
         clip_en_ff <= 1'b1;
         pole_ff    <= dcsc_pkg::POLE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dcsc_pkg::CSR_DC_ENABLE:   dc_en_ff   <= csr_wdata[0];
            dcsc_pkg::CSR_CLIP_ENABLE: clip_en_ff <= csr_wdata[0];
            dcsc_pkg::CSR_POLE_COEFF:  pole_ff    <= csr_wdata[dcsc_pkg::POLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // DC blocker arithmetic: y = x - x_prev + round(R * y_prev)
   always_comb begin
      rnd    = mac_p[SB+16:16];
      y_wide = SUM_W'(x_ff) - SUM_W'(prev_in_ff[cidx_ff]) + SUM_W'(rnd);
      if (y_wide > SUM_W'(S_MAX)) begin
         y_sat = S_MAX;
      end else if (y_wide < SUM_W'(S_MIN)) begin
         y_sat = S_MIN;
      end else begin
         y_sat = y_wide[SB-1:0];
      end
   end

   always_comb begin
      mag    = x_ff[SB-1] ? -MW'(x_ff) : MW'(x_ff);
      diff   = (rom_q_ff >= lo_ff) ? (rom_q_ff - lo_ff) : '0;
      interp = lo_ff + SB'(mac_p[PW-1:SHIFT]);
   end

   // shared unit operand selection
   always_comb begin
      mac_op = '0;
      case (state_ff)
         ST_DC_MUL: begin
            mac_op.a = MW'($signed({1'b0, pole_use}));
            mac_op.b = MW'(prev_out_ff[cidx_ff]);
            mac_op.c = dcsc_pkg::ADD_W'(32768);
         end
         ST_CLIP_POS: begin
            mac_op.a = mag;
            mac_op.b = MW'(CLIP_TABLE_DEPTH);
         end
         ST_CLIP_HI: begin
            mac_op.a = $signed({1'b0, diff});
            mac_op.b = MW'($signed({1'b0, frac_ff}));
            mac_op.c = dcsc_pkg::ADD_W'(1 << (SHIFT - 1));
         end
         default: ;
      endcase
   end

   // table read address: low point from the fresh position, then the next one
   always_comb begin
      case (state_ff)
         ST_CLIP_IDX: rom_addr = mac_p[SHIFT +: AW];
         ST_CLIP_LO:  rom_addr = idx_ff + AW'(1);
         default:     rom_addr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= TANH_ROM[rom_addr];
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      cidx_in      = cidx_ff;
      chan_in      = chan_ff;
      sign_in      = sign_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      lo_in        = lo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      state_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_data.bad_value ? '0 : req_data.sample_in;
               chan_in = req_data.chan;
               cidx_in = (int'(req_data.chan) < CHANNELS) ? CH_W'(req_data.chan)
                                                          : CH_W'(CHANNELS - 1);
               if (dc_en_ff) begin
                  state_in = ST_DC_MUL;
               end else if (clip_en_ff) begin
                  state_in = ST_CLIP_POS;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DC_MUL: begin
            state_in = ST_DC_SUM;
         end
         ST_DC_SUM: begin
            x_in     = y_sat;
            state_we = 1'b1;
            state_in = clip_en_ff ? ST_CLIP_POS : ST_FINISH;
         end
         ST_CLIP_POS: begin
            sign_in  = x_ff[SB-1];
            state_in = ST_CLIP_IDX;
         end
         ST_CLIP_IDX: begin
            idx_in   = mac_p[SHIFT +: AW];
            frac_in  = mac_p[SHIFT-1:0];
            state_in = ST_CLIP_LO;
         end
         ST_CLIP_LO: begin
            lo_in = rom_q_ff;
            if (idx_ff == IDX_LAST) begin
               // magnitude at full scale: last point, no interpolation
               x_in     = sign_ff ? -rom_q_ff : rom_q_ff;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_CLIP_HI;
            end
         end
         ST_CLIP_HI: begin
            state_in = ST_CLIP_INT;
         end
         ST_CLIP_INT: begin
            x_in     = sign_ff ? -interp : interp;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.sample_out = x_ff;
               rsp_data_in.out_chan   = chan_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      cidx_ff     <= cidx_in;
      chan_ff     <= chan_in;
      sign_ff     <= sign_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      lo_ff       <= lo_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            prev_in_ff[i]  <= '0;
            prev_out_ff[i] <= '0;
         end
      end else if (state_we) begin
         prev_in_ff[cidx_ff]  <= x_ff;
         prev_out_ff[cidx_ff] <= y_sat;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result only appears out of the completion state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("rsp_valid rose outside completion");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a transaction while busy");

   // table index never runs past the last point
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLIP_LO) |-> (idx_ff <= IDX_LAST))
      else $error("tanh table index out of range");

   // a waiting result holds until the receiver takes it
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("waiting transaction changed before acceptance");

endmodule
`default_nettype wire

// ===== design/dcsc_mac.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcsc_mac
// Shared signed multiply-add with a registered result, reused by the
// sequencer for the pole product, table position and interpolation.
// ---------------------------------------------------------------------------
module dcsc_mac (
   input  wire logic                             clock,
   input  wire dcsc_pkg::mac_op_type             op,
   output logic signed [dcsc_pkg::PROD_W-1:0]    prod_ff
);

   logic signed [dcsc_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = op.a * op.b + dcsc_pkg::PROD_W'(op.c);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire
